[hdl/sha256_pkg.sv]
// Package with SHA-256 constants, types and round functions.
`timescale 1ns / 1ps
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic        OP_ABSORB = 1'b0;
  localparam logic [7:0]  PAD_BYTE  = 8'h80;
  localparam logic [5:0]  LEN_POS   = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sm_s0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sm_s1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[hdl/sha256_stream_hasher_top.sv]
// Streaming SHA-256 hasher: byte intake, padding, iterative compression, digest output.
//
//  channel  | dir | tdata                         | tuser | tlast
//  s_axis   | in  | [7:0] data_byte               | op    | -
//  m_axis   | out | [31:0] digest_word, [34:32] word_index, zeros | -   | last
//
// A data byte is taken on each s_axis handshake; the 64th byte of a block starts the round
// loop (ST_ROUND) and then the add step (ST_ADD), during which s_axis_tready is low.
// A finish word places the pad byte, then zero-fills one byte a cycle up to the end
// of the block, placing the bit length where it fits, runs one or two compressions,
// then hands out eight digest words.
// The single round unit and the 16-word expansion window make the compression iterative.
// Reset is synchronous and loads the initial hash; a stalled m_axis holds.
`timescale 1ns / 1ps
module sha256_stream_hasher_top import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zeros
  output logic        m_axis_tlast    // last
);

  state_t state, state_next;
  logic [31:0] hash [8];
  logic [31:0] wv [8];
  logic [31:0] w [16];
  logic [5:0]  fill;
  logic [63:0] bit_count;
  logic [5:0]  round;
  logic        final_pass;   // this compression ends the message
  logic        len_done;     // length block already placed
  logic [2:0]  out_idx;

  logic accept_in;
  logic [31:0] t1, t2, w_new;

  assign accept_in = s_axis_tvalid && s_axis_tready;

  // Round datapath: one round and one schedule word per cycle.
  assign w_new = w[0] + sm_s0(w[1]) + w[9] + sm_s1(w[14]);
  assign t1 = wv[7] + big_s1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
              + ROUND_K[round] + w[0];
  assign t2 = big_s0(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept_in) begin
          if (s_axis_tuser == OP_ABSORB) begin
            if (fill == 6'd63) state_next = ST_ROUND;
          end else if (fill == 6'd63) begin
            state_next = ST_ROUND;
          end else begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill == 6'd63) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (round == 6'd63) state_next = ST_ADD;
      end
      ST_ADD: begin
        if (!final_pass) state_next = ST_IDLE;
        else if (len_done) state_next = ST_EMIT;
        else state_next = ST_PAD;
      end
      ST_EMIT: begin
        if (m_axis_tready && out_idx == 3'd7) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    m_axis_tvalid = (state == ST_EMIT);
    m_axis_tdata  = {5'd0, out_idx, hash[out_idx]};
    m_axis_tlast  = (out_idx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Byte placement, padding, rounds and hash update.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) hash[i] <= INIT_HASH[i];
      fill       <= '0;
      bit_count  <= '0;
      round      <= '0;
      final_pass <= 1'b0;
      len_done   <= 1'b0;
      out_idx    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept_in) begin
            if (s_axis_tuser == OP_ABSORB) begin
              w[fill[5:2]][(3 - fill[1:0]) * 8 +: 8] <= s_axis_tdata;
              bit_count <= bit_count + 64'd8;
              fill <= fill + 6'd1;
              final_pass <= 1'b0;
              for (int i = 0; i < 8; i++) wv[i] <= hash[i];
              round <= '0;
            end else begin
              w[fill[5:2]][(3 - fill[1:0]) * 8 +: 8] <= PAD_BYTE;
              final_pass <= 1'b1;
              len_done <= (fill < LEN_POS);
              fill <= fill + 6'd1;
              if (fill == 6'd63) begin
                for (int i = 0; i < 8; i++) wv[i] <= hash[i];
                round <= '0;
              end
            end
          end
        end
        ST_PAD: begin
          // Zero up to the length field, then place the bit length if it fits.
          if (len_done && fill >= LEN_POS) begin
            w[14] <= bit_count[63:32];
            w[15] <= bit_count[31:0];
          end else begin
            w[fill[5:2]][(3 - fill[1:0]) * 8 +: 8] <= 8'h00;
          end
          fill <= fill + 6'd1;
          if (fill == 6'd63) begin
            for (int i = 0; i < 8; i++) wv[i] <= hash[i];
            round <= '0;
          end
        end
        ST_ROUND: begin
          wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4];
          wv[4] <= wv[3] + t1;
          wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0];
          wv[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= w_new;
          round <= round + 6'd1;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) hash[i] <= hash[i] + wv[i];
          len_done <= 1'b1;
          fill <= '0;
          out_idx <= '0;
        end
        ST_EMIT: begin
          if (m_axis_tready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) hash[i] <= INIT_HASH[i];
              bit_count  <= '0;
              fill       <= '0;
              final_pass <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
